[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clock, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define HTW_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// condition must never be seen
`define HTW_NEVER(name, cond, msg) \
   `HTW_ASSERT(name, !(cond), msg)

`endif

[rtl/htw_pkg.sv]
// ----------------------------------------------------------------------------
// htw_pkg
// Constants, codes and helpers of the hierarchical timer wheel.
// ----------------------------------------------------------------------------
package htw_pkg;

   // wheel geometry
   localparam int LEVEL0_SLOTS = 100;
   localparam int LEVEL1_SLOTS = 60;
   localparam int LEVEL2_SLOTS = 60;
   localparam int SLOT_DEPTH   = 8;

   localparam int TOTAL_SLOTS = LEVEL0_SLOTS + LEVEL1_SLOTS + LEVEL2_SLOTS;
   localparam int STORE_DEPTH = TOTAL_SLOTS * SLOT_DEPTH;
   localparam int MAX_SLOTS   = (LEVEL0_SLOTS > LEVEL1_SLOTS) ?
                                ((LEVEL0_SLOTS > LEVEL2_SLOTS) ? LEVEL0_SLOTS : LEVEL2_SLOTS) :
                                ((LEVEL1_SLOTS > LEVEL2_SLOTS) ? LEVEL1_SLOTS : LEVEL2_SLOTS);

   localparam int POS_W   = $clog2(MAX_SLOTS);
   localparam int SLOTS_W = POS_W + 1;
   localparam int SLOT_AW = $clog2(TOTAL_SLOTS);
   localparam int STORE_AW = $clog2(STORE_DEPTH);
   localparam int FILL_W  = $clog2(SLOT_DEPTH + 1);
   localparam int TICK_W  = 16;
   localparam int ID_W    = 16;
   localparam int DELAY_W = 32;
   localparam int LIM_W   = TICK_W + SLOTS_W;
   localparam int LV_W    = 2;

   // operation codes
   localparam logic FUNC_ADD  = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   // result kinds and status
   localparam logic KIND_ACK     = 1'b0;
   localparam logic KIND_EXPIRED = 1'b1;
   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_FULL  = 1'b1;

   // register indexes
   localparam logic [1:0] REG_BASE_TICK = 2'd0;
   localparam logic [1:0] REG_L0_TICK   = 2'd1;
   localparam logic [1:0] REG_L1_TICK   = 2'd2;
   localparam logic [1:0] REG_L2_TICK   = 2'd3;

   localparam logic [LV_W-1:0] LV0 = 2'd0;
   localparam logic [LV_W-1:0] LV1 = 2'd1;
   localparam logic [LV_W-1:0] LV2 = 2'd2;

   // slots in a level
   function automatic logic [SLOTS_W-1:0] slots_of(input logic [LV_W-1:0] lv);
      case (lv)
         LV0:     slots_of = SLOTS_W'(LEVEL0_SLOTS);
         LV1:     slots_of = SLOTS_W'(LEVEL1_SLOTS);
         default: slots_of = SLOTS_W'(LEVEL2_SLOTS);
      endcase
   endfunction

   // first slot of a level in the flat slot space
   function automatic logic [SLOT_AW-1:0] base_of(input logic [LV_W-1:0] lv);
      case (lv)
         LV0:     base_of = '0;
         LV1:     base_of = SLOT_AW'(LEVEL0_SLOTS);
         default: base_of = SLOT_AW'(LEVEL0_SLOTS + LEVEL1_SLOTS);
      endcase
   endfunction

   // a zero tick acts as one
   function automatic logic [TICK_W-1:0] eff_tick(input logic [TICK_W-1:0] t);
      eff_tick = (t == '0) ? TICK_W'(1) : t;
   endfunction

endpackage

[rtl/htw_ram.sv]
// ----------------------------------------------------------------------------
// htw_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module htw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

[rtl/hierarchical_timer_wheel.sv]
// ----------------------------------------------------------------------------
// hierarchical_timer_wheel
// Three-level timing wheel, slot contents and fill counts held in RAM.
// ----------------------------------------------------------------------------
// Usage:
//  - Command channel: an item transfers when start is high and busy is low.
//    req_func selects add (timer id + delay) or one base tick.
//  - Result channel: rsp_strobe marks each result for one cycle; rsp_last
//    flags the final result of an item. The receiver cannot stall.
//  - An add keeps busy high through a tick-times-slots multiply, a
//    level select, a 32-step restoring divide of the delay by the level tick
//    (the bulk of the time), then a read-modify-write of the slot fill count.
//    The ack is strobed in the cycle after, when busy is already low.
//  - A tick advances the levels and fetches three fill counts, then reads
//    out each expired id (store RAM read, one per cycle), one level after
//    another; up to 24 ids, all results strobed while busy; the next item
//    can transfer once busy falls.
//  - One item is in work at a time; for a tick, busy is high until its
//    last result is issued.
//  - Reset clears levels, fill counts (per-slot valid bits) and restores
//    the tick registers; no clearing pass is needed.
//  - Configuration over the APB port, only while the block is idle.
// ----------------------------------------------------------------------------
module hierarchical_timer_wheel (
   input  logic                       clock,
   input  logic                       reset,
   // command channel
   input  logic                       start,
   output logic                       busy,
   input  logic                       req_func,
   input  logic [htw_pkg::ID_W-1:0]    req_timer_id,
   input  logic [htw_pkg::DELAY_W-1:0] req_delay_ms,
   // result channel
   output logic                       rsp_strobe,
   output logic                       rsp_kind,
   output logic [htw_pkg::ID_W-1:0]    rsp_expired_id,
   output logic                       rsp_status,
   output logic                       rsp_last,
   // configuration
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [3:0]                 paddr,
   input  logic [31:0]                pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);
   import htw_pkg::*;

   `include "assert_macros.svh"

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_AMUL  = 4'd1;
   localparam logic [3:0] S_ASEL  = 4'd2;
   localparam logic [3:0] S_ADIV  = 4'd3;
   localparam logic [3:0] S_ASLOT = 4'd4;
   localparam logic [3:0] S_AWR   = 4'd5;
   localparam logic [3:0] S_TCALC = 4'd6;
   localparam logic [3:0] S_FRD   = 4'd7;
   localparam logic [3:0] S_FCAP  = 4'd8;
   localparam logic [3:0] S_EMIT  = 4'd9;

   // control and config state
   logic [3:0]        state_ff, state_in;
   logic [TICK_W-1:0] base_tick_ff, base_tick_in;
   logic [TICK_W-1:0] tick_ff [3];
   logic [TICK_W-1:0] tick_in [3];
   logic [POS_W-1:0]  pos_ff [3];
   logic [POS_W-1:0]  pos_in [3];
   logic [TICK_W-1:0] elap_ff [3];
   logic [TICK_W-1:0] elap_in [3];
   logic              strobe_ff, strobe_in;
   logic [TOTAL_SLOTS-1:0] valid_ff, valid_in;

   // working registers
   logic [ID_W-1:0]    id_ff, id_in;
   logic [DELAY_W-1:0] delay_ff, delay_in;
   logic [LIM_W-1:0]   lim0_ff, lim0_in, lim1_ff, lim1_in;
   logic [LV_W-1:0]    lv_ff, lv_in;
   logic [TICK_W-1:0]  div_ff, div_in, rem_ff, rem_in;
   logic [DELAY_W-1:0] quo_ff, quo_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic [SLOT_AW-1:0] slot_ff, slot_in;
   logic [2:0]         adv_ff, adv_in;
   logic [FILL_W-1:0]  fcnt_ff [3];
   logic [FILL_W-1:0]  fcnt_in [3];
   logic [FILL_W-1:0]  idx_ff, idx_in;
   logic               kind_ff, kind_in, status_ff, status_in, last_ff, last_in;
   logic               fvq_ff;

   // memory ports
   logic                fill_we;
   logic [SLOT_AW-1:0]  fill_raddr;
   logic [FILL_W-1:0]   fill_wdata, fill_rdata, fill_q;
   logic                store_we;
   logic [STORE_AW-1:0] store_waddr, store_raddr;
   logic [ID_W-1:0]     store_rdata;

   // config transfer
   logic cfg_wr;
   assign cfg_wr = psel && penable && pwrite && pready;
   assign pready = 1'b1;

   always_comb begin
      case (paddr[3:2])
         REG_BASE_TICK: prdata = 32'(base_tick_ff);
         REG_L0_TICK:   prdata = 32'(tick_ff[0]);
         REG_L1_TICK:   prdata = 32'(tick_ff[1]);
         default:       prdata = 32'(tick_ff[2]);
      endcase
   end

   // fill count of a never-written slot reads as zero
   assign fill_q = fvq_ff ? fill_rdata : '0;

   // next-state logic
   always_comb begin
      logic [TICK_W:0]    trial;
      logic [SLOTS_W-1:0] tk, slots;
      logic [SLOTS_W:0]   psum;
      logic [SLOT_AW-1:0] sidx;
      logic [TICK_W:0]    esum, erem;
      logic [TICK_W-1:0]  t;
      logic               later_zero;

      state_in     = state_ff;
      base_tick_in = base_tick_ff;
      tick_in      = tick_ff;
      pos_in       = pos_ff;
      elap_in      = elap_ff;
      strobe_in    = 1'b0;
      valid_in     = valid_ff;
      id_in        = id_ff;
      delay_in     = delay_ff;
      lim0_in      = lim0_ff;
      lim1_in      = lim1_ff;
      lv_in        = lv_ff;
      div_in       = div_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      slot_in      = slot_ff;
      adv_in       = adv_ff;
      fcnt_in      = fcnt_ff;
      idx_in       = idx_ff;
      kind_in      = kind_ff;
      status_in    = status_ff;
      last_in      = last_ff;

      fill_we     = 1'b0;
      fill_wdata  = '0;
      fill_raddr  = slot_ff;
      store_we    = 1'b0;
      store_waddr = STORE_AW'(slot_ff * SLOT_DEPTH) + STORE_AW'(fill_q);
      store_raddr = '0;

      trial      = '0;
      tk         = '0;
      slots      = slots_of(lv_ff);
      psum       = '0;
      sidx       = '0;
      esum       = '0;
      erem       = '0;
      t          = '0;
      later_zero = 1'b0;

      // register writes
      if (cfg_wr) begin
         case (paddr[3:2])
            REG_BASE_TICK: base_tick_in = pwdata[TICK_W-1:0];
            REG_L0_TICK:   tick_in[0]   = pwdata[TICK_W-1:0];
            REG_L1_TICK:   tick_in[1]   = pwdata[TICK_W-1:0];
            default:       tick_in[2]   = pwdata[TICK_W-1:0];
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               id_in    = req_timer_id;
               delay_in = (req_delay_ms == '0) ? DELAY_W'(1) : req_delay_ms;
               state_in = (req_func == FUNC_TICK) ? S_TCALC : S_AMUL;
            end
         end
         // level spans
         S_AMUL: begin
            lim0_in  = LIM_W'(eff_tick(tick_ff[0])) * LIM_W'(LEVEL0_SLOTS);
            lim1_in  = LIM_W'(eff_tick(tick_ff[1])) * LIM_W'(LEVEL1_SLOTS);
            state_in = S_ASEL;
         end
         // pick a level, set up the divide
         S_ASEL: begin
            if (delay_ff < DELAY_W'(lim0_ff)) begin
               lv_in = LV0;
            end else if (delay_ff < DELAY_W'(lim1_ff)) begin
               lv_in = LV1;
            end else begin
               lv_in = LV2;
            end
            div_in   = eff_tick(tick_ff[lv_in]);
            rem_in   = '0;
            quo_in   = delay_ff;
            cnt_in   = '0;
            state_in = S_ADIV;
         end
         // restoring divide, one quotient bit a cycle
         S_ADIV: begin
            trial = {rem_ff, quo_ff[DELAY_W-1]};
            if (trial >= {1'b0, div_ff}) begin
               rem_in = TICK_W'(trial - {1'b0, div_ff});
               quo_in = {quo_ff[DELAY_W-2:0], 1'b1};
            end else begin
               rem_in = trial[TICK_W-1:0];
               quo_in = {quo_ff[DELAY_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               state_in = S_ASLOT;
            end
         end
         // clamp ticks, find the slot, fetch its fill
         S_ASLOT: begin
            if (quo_ff == '0) begin
               tk = SLOTS_W'(1);
            end else if (quo_ff >= DELAY_W'(slots)) begin
               tk = slots - SLOTS_W'(1);
            end else begin
               tk = quo_ff[SLOTS_W-1:0];
            end
            psum = (SLOTS_W+1)'(pos_ff[lv_ff]) + (SLOTS_W+1)'(tk);
            if (psum >= (SLOTS_W+1)'(slots)) begin
               psum = psum - (SLOTS_W+1)'(slots);
            end
            sidx       = base_of(lv_ff) + SLOT_AW'(psum);
            slot_in    = sidx;
            fill_raddr = sidx;
            state_in   = S_AWR;
         end
         // append id or report a full slot
         S_AWR: begin
            if (fill_q >= FILL_W'(SLOT_DEPTH)) begin
               status_in = STATUS_FULL;
            end else begin
               status_in  = STATUS_OK;
               store_we   = 1'b1;
               fill_we    = 1'b1;
               fill_wdata = fill_q + FILL_W'(1);
            end
            kind_in   = KIND_ACK;
            last_in   = 1'b1;
            strobe_in = 1'b1;
            state_in  = S_IDLE;
         end
         // advance every level whose time has come
         S_TCALC: begin
            for (int i = 0; i < 3; i++) begin
               t    = eff_tick(tick_ff[i]);
               esum = (TICK_W+1)'(elap_ff[i]) + (TICK_W+1)'(base_tick_ff);
               if (esum >= (TICK_W+1)'(t)) begin
                  erem = esum - (TICK_W+1)'(t);
                  if (erem >= (TICK_W+1)'(t)) begin
                     erem = (TICK_W+1)'(t) - (TICK_W+1)'(1);
                  end
                  elap_in[i] = erem[TICK_W-1:0];
                  pos_in[i]  = ((SLOTS_W)'(pos_ff[i]) + SLOTS_W'(1) ==
                                slots_of(LV_W'(i))) ? '0 : pos_ff[i] + POS_W'(1);
                  adv_in[i]  = 1'b1;
               end else begin
                  elap_in[i] = esum[TICK_W-1:0];
                  adv_in[i]  = 1'b0;
               end
            end
            lv_in    = LV0;
            state_in = S_FRD;
         end
         // fetch the fill count of the current slot of a level
         S_FRD: begin
            sidx       = base_of(lv_ff) + SLOT_AW'(pos_ff[lv_ff]);
            slot_in    = sidx;
            fill_raddr = sidx;
            state_in   = S_FCAP;
         end
         // for a level that advanced, keep the count and empty the slot
         S_FCAP: begin
            if (adv_ff[lv_ff]) begin
               fcnt_in[lv_ff] = fill_q;
               fill_we        = 1'b1;
               fill_wdata     = '0;
            end else begin
               fcnt_in[lv_ff] = '0;
            end
            if (lv_ff == LV2) begin
               lv_in    = LV0;
               idx_in   = '0;
               state_in = S_EMIT;
            end else begin
               lv_in    = lv_ff + LV_W'(1);
               state_in = S_FRD;
            end
         end
         // read out expired ids, one a cycle
         S_EMIT: begin
            case (lv_ff)
               LV0:     later_zero = (fcnt_ff[1] == '0) && (fcnt_ff[2] == '0);
               LV1:     later_zero = (fcnt_ff[2] == '0);
               default: later_zero = 1'b1;
            endcase
            if (idx_ff < fcnt_ff[lv_ff]) begin
               sidx        = base_of(lv_ff) + SLOT_AW'(pos_ff[lv_ff]);
               store_raddr = STORE_AW'(sidx * SLOT_DEPTH) + STORE_AW'(idx_ff);
               strobe_in   = 1'b1;
               kind_in     = KIND_EXPIRED;
               status_in   = STATUS_OK;
               last_in     = (idx_ff + FILL_W'(1) == fcnt_ff[lv_ff]) && later_zero;
               idx_in      = idx_ff + FILL_W'(1);
            end else if (lv_ff == LV2) begin
               state_in = S_IDLE;
            end else begin
               lv_in  = lv_ff + LV_W'(1);
               idx_in = '0;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (fill_we) begin
         valid_in[slot_ff] = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         base_tick_ff <= TICK_W'(10);
         tick_ff[0]   <= TICK_W'(10);
         tick_ff[1]   <= TICK_W'(1000);
         tick_ff[2]   <= TICK_W'(60000);
         pos_ff       <= '{default: '0};
         elap_ff      <= '{default: '0};
         strobe_ff    <= 1'b0;
         valid_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         base_tick_ff <= base_tick_in;
         tick_ff      <= tick_in;
         pos_ff       <= pos_in;
         elap_ff      <= elap_in;
         strobe_ff    <= strobe_in;
         valid_ff     <= valid_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      id_ff     <= id_in;
      delay_ff  <= delay_in;
      lim0_ff   <= lim0_in;
      lim1_ff   <= lim1_in;
      lv_ff     <= lv_in;
      div_ff    <= div_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      cnt_ff    <= cnt_in;
      slot_ff   <= slot_in;
      adv_ff    <= adv_in;
      fcnt_ff   <= fcnt_in;
      idx_ff    <= idx_in;
      kind_ff   <= kind_in;
      status_ff <= status_in;
      last_ff   <= last_in;
      fvq_ff    <= valid_ff[fill_raddr];
   end

   // slot fill counts
   htw_ram #(
      .WIDTH (FILL_W),
      .DEPTH (TOTAL_SLOTS)
   ) u_fill_ram (
      .clock (clock),
      .we    (fill_we),
      .waddr (slot_ff),
      .wdata (fill_wdata),
      .raddr (fill_raddr),
      .rdata (fill_rdata)
   );

   // slot contents
   htw_ram #(
      .WIDTH (ID_W),
      .DEPTH (STORE_DEPTH)
   ) u_store_ram (
      .clock (clock),
      .we    (store_we),
      .waddr (store_waddr),
      .wdata (id_ff),
      .raddr (store_raddr),
      .rdata (store_rdata)
   );

   // outputs
   assign busy           = (state_ff != S_IDLE);
   assign rsp_strobe     = strobe_ff;
   assign rsp_kind       = kind_ff;
   assign rsp_status     = status_ff;
   assign rsp_last       = last_ff;
   assign rsp_expired_id = (kind_ff == KIND_EXPIRED) ? store_rdata : '0;

   // checks
   `HTW_ASSERT(a_busy_after_start, start && !busy |=> busy, "accepted item did not raise busy")
   `HTW_ASSERT(a_ack_is_last, rsp_strobe && (rsp_kind == KIND_ACK) |-> rsp_last, "add ack not last")
   `HTW_NEVER(a_fill_bound, fill_we && (fill_wdata > FILL_W'(SLOT_DEPTH)), "fill count overrun")

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the timer wheel: a queue of add and tick commands
// is driven at random pace, a local wheel model predicts acks and expired
// ids, and the monitor compares every strobed result in order.
// ----------------------------------------------------------------------------
module tb_top;
   import htw_pkg::*;

   typedef struct packed {
      logic                func;
      logic [ID_W-1:0]     id;
      logic [DELAY_W-1:0]  delay;
   } cmd_type;

   typedef struct packed {
      logic            kind;
      logic [ID_W-1:0] id;
      logic            status;
      logic            last;
   } res_type;

   logic clock, reset;
   logic start, busy;
   logic req_func;
   logic [ID_W-1:0] req_timer_id;
   logic [DELAY_W-1:0] req_delay_ms;
   logic rsp_strobe, rsp_kind, rsp_status, rsp_last;
   logic [ID_W-1:0] rsp_expired_id;
   logic psel, penable, pwrite, pready;
   logic [3:0] paddr;
   logic [31:0] pwdata, prdata;

   hierarchical_timer_wheel u_top (.*);

   // wheel model state
   logic [TICK_W-1:0] m_base;
   logic [TICK_W-1:0] m_tick [3];
   logic [ID_W-1:0]   m_store [TOTAL_SLOTS][SLOT_DEPTH];
   int unsigned       m_fill [TOTAL_SLOTS];
   int unsigned       m_pos [3];
   int unsigned       m_elapsed [3];

   cmd_type cmd_q[$];
   res_type expected_q[$];
   int   errors = 0;
   bit   calm = 0;
   bit   cfg_busy = 0;

   // transfer seen at the last rising edge
   logic taken;

   function automatic int unsigned lv_slots(int lv);
      return (lv == 0) ? LEVEL0_SLOTS : (lv == 1) ? LEVEL1_SLOTS : LEVEL2_SLOTS;
   endfunction

   function automatic int unsigned lv_base(int lv);
      return (lv == 0) ? 0 : (lv == 1) ? LEVEL0_SLOTS : LEVEL0_SLOTS + LEVEL1_SLOTS;
   endfunction

   function automatic longint unsigned tick_of(int lv);
      return (m_tick[lv] == 0) ? 1 : m_tick[lv];
   endfunction

   // append to the tail of the queues
   task automatic expect_result(input res_type r);
      expected_q = {expected_q, r};
   endtask

   task automatic enqueue_cmd(input cmd_type c);
      cmd_q = {cmd_q, c};
   endtask

   // work out the results of one accepted command
   task automatic predict_wheel(input cmd_type c);
      longint unsigned dly, ticks;
      int lv, s, n0;
      longint unsigned t, sum, rem;
      res_type r;
      if (c.func == FUNC_ADD) begin
         dly = (c.delay == 0) ? 1 : c.delay;
         if (dly < tick_of(0) * LEVEL0_SLOTS) lv = 0;
         else if (dly < tick_of(1) * LEVEL1_SLOTS) lv = 1;
         else lv = 2;
         ticks = dly / tick_of(lv);
         if (ticks == 0) ticks = 1;
         if (ticks >= lv_slots(lv)) ticks = lv_slots(lv) - 1;
         s = lv_base(lv) + int'((m_pos[lv] + ticks) % lv_slots(lv));
         r = res_type'{KIND_ACK, '0, STATUS_OK, 1'b1};
         if (m_fill[s] >= SLOT_DEPTH) r.status = STATUS_FULL;
         else begin
            m_store[s][m_fill[s]] = c.id;
            m_fill[s]++;
         end
         expect_result(r);
         return;
      end
      n0 = expected_q.size();
      for (lv = 0; lv < 3; lv++) begin
         t = tick_of(lv);
         sum = m_elapsed[lv] + m_base;
         if (sum >= t) begin
            rem = sum - t;
            if (rem >= t) rem = t - 1;
            m_elapsed[lv] = rem;
            m_pos[lv] = (m_pos[lv] + 1) % lv_slots(lv);
            s = lv_base(lv) + m_pos[lv];
            for (int i = 0; i < m_fill[s]; i++)
               expect_result(res_type'{KIND_EXPIRED, m_store[s][i], STATUS_OK, 1'b0});
            m_fill[s] = 0;
         end else
            m_elapsed[lv] = sum;
      end
      if (expected_q.size() > n0) expected_q[$].last = 1'b1;
   endtask

   // clock
   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // driver: commands go out on the falling edge, held until they transfer
   always @(negedge clock) begin
      cmd_type c;
      if (reset) begin
         start        <= 1'b0;
         req_func     <= 1'b0;
         req_timer_id <= '0;
         req_delay_ms <= '0;
      end else if (!start || taken) begin
         if (!cfg_busy && cmd_q.size() > 0 && (calm || $urandom_range(99) >= 27)) begin
            c = cmd_q.pop_front();
            req_func     <= c.func;
            req_timer_id <= c.id;
            req_delay_ms <= c.delay;
            start        <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // predict at the transfer edge
   always @(posedge clock) begin
      taken <= !reset && start && !busy;
      if (!reset && start && !busy)
         predict_wheel(cmd_type'{req_func, req_timer_id, req_delay_ms});
   end

   // monitor
   always @(posedge clock) begin
      res_type got, want;
      if (!reset && rsp_strobe) begin
         got = res_type'{rsp_kind, rsp_expired_id, rsp_status, rsp_last};
         if (expected_q.size() == 0) begin
            $display("%0t unexpected result: expected none, actual %p", $time, got);
            errors++;
         end else begin
            want = expected_q.pop_front();
            if (got !== want) begin
               $display("%0t result mismatch: expected %p, actual %p", $time, want, got);
               errors++;
            end
         end
      end
   end

   // register write over the config port, block idle
   task automatic csr_write(input logic [1:0] idx, input logic [15:0] val);
      @(negedge clock);
      psel <= 1; penable <= 0; pwrite <= 1;
      paddr <= {idx, 2'b00}; pwdata <= {16'h0, val};
      @(negedge clock);
      penable <= 1;
      @(negedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
      if (idx == REG_BASE_TICK) m_base = val;
      else m_tick[idx - 1] = val;
   endtask

   task automatic wait_drained();
      while (cmd_q.size() > 0 || expected_q.size() > 0 || start || busy)
         @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   function automatic cmd_type add_cmd(logic [ID_W-1:0] id, logic [DELAY_W-1:0] d);
      return cmd_type'{FUNC_ADD, id, d};
   endfunction

   function automatic cmd_type tick_cmd();
      return cmd_type'{FUNC_TICK, ID_W'($urandom), DELAY_W'($urandom)};
   endfunction

   // phase of random work under one register setting
   task automatic run_phase(input int n, input logic [15:0] b, input logic [15:0] t0,
                            input logic [15:0] t1, input logic [15:0] t2);
      int span;
      int unsigned pick;
      logic [DELAY_W-1:0] d;
      cfg_busy = 1;
      @(negedge clock);
      csr_write(REG_BASE_TICK, b);
      csr_write(REG_L0_TICK, t0);
      csr_write(REG_L1_TICK, t1);
      csr_write(REG_L2_TICK, t2);
      cfg_busy = 0;
      span = 40 * ((t0 == 0) ? 1 : t0);
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(9);
         case (pick) inside
            [0:3]:   d = DELAY_W'($urandom_range(span));
            4:       d = $urandom;
            5:       d = DELAY_W'($urandom_range(70 * int'((t1 == 0) ? 1 : t1)));
            default: d = 'x;
         endcase
         if ($isunknown(d)) enqueue_cmd(tick_cmd());
         else enqueue_cmd(add_cmd(ID_W'($urandom), d));
      end
      wait_drained();
   endtask

   // stimulus
   initial begin
      psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
      m_base = 10; m_tick[0] = 10; m_tick[1] = 1000; m_tick[2] = 60000;
      foreach (m_fill[i]) m_fill[i] = 0;
      foreach (m_pos[i]) begin m_pos[i] = 0; m_elapsed[i] = 0; end
      reset = 1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: zero delay, extremes, full slot, expiry
      enqueue_cmd(add_cmd(16'h0000, 0));
      enqueue_cmd(add_cmd(16'hFFFF, 32'hFFFF_FFFF));
      enqueue_cmd(add_cmd(16'h5A5A, 999));
      enqueue_cmd(add_cmd(16'hA5A5, 1000));
      enqueue_cmd(add_cmd(16'h1234, 59999));
      enqueue_cmd(add_cmd(16'h4321, 60000));
      for (int i = 0; i < 9; i++) enqueue_cmd(add_cmd(16'(i + 1), 10));
      for (int i = 0; i < 3; i++) enqueue_cmd(tick_cmd());
      wait_drained();

      // base tick above level ticks, zero ticks, extremes
      run_phase(40, 16'd7, 16'd0, 16'd0, 16'd1);
      run_phase(40, 16'hFFFF, 16'd1, 16'd3, 16'd0);
      run_phase(40, 16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      calm = 1;
      run_phase(80, 16'd3, 16'd5, 16'd20, 16'd200);
      calm = 0;
      run_phase(150, 16'd2, 16'd2, 16'd7, 16'd30);
      run_phase(150, 16'd10, 16'd10, 16'd1000, 16'd60000);

      if (errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("[FAIL] regression broken");
      $finish;
   end
endmodule

[sim.f]
+incdir+rtl
rtl/htw_pkg.sv
rtl/htw_ram.sv
rtl/hierarchical_timer_wheel.sv
tb/tb_top.sv
